>>> hdl/hml_pkg.sv
package hml_pkg;

    localparam int ROW_WIDTH_W = 7;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 7'd64;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       row_done;
    } mirror_t;

    typedef enum logic {
        HML_FILL,
        HML_DRAIN
    } hml_state_t;

    // controller -> datapath
    typedef struct packed {
        logic write;
        logic start;
        logic issue;
        logic load;
        logic take;
    } hml_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic row_end;
        logic reads_left;
        logic rd_valid;
        logic out_valid;
    } hml_status_t;

endpackage

>>> hdl/horizontal_mirror_line_top.sv
// Channel   Direction  Handshake               Payload
// pixel     in         pixel_valid/pixel_stall hml_pkg::pixel_t (red, green, blue)
// mirror    out        mirror_valid/mirror_stall hml_pkg::mirror_t (rgb, row_done)
// cfg       in         cfg_valid/cfg_ready     row_width, 7 bits
//
// A row of W pixels is taken one word per cycle into the row buffer. The word that
// completes the row starts readout: W words leave in reverse column order, one per
// cycle when mirror is not stalled, through the registered buffer read port and the
// output register. Input is stalled during readout.
// Reset clears the column count, row_width returns to 64; buffer contents stay.
// A stall on mirror holds the output word and pauses buffer reads.
module horizontal_mirror_line_top #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  hml_pkg::pixel_t                 pixel,
    output logic                            mirror_valid,
    input  logic                            mirror_stall,
    output hml_pkg::mirror_t                mirror,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hml_pkg::ROW_WIDTH_W-1:0] cfg_data
);

    hml_pkg::hml_cmd_t    cmd;
    hml_pkg::hml_status_t status;

    assign cfg_ready = 1'b1;

    hml_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .mirror_stall (mirror_stall),
        .status       (status),
        .cmd          (cmd)
    );

    hml_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .pixel        (pixel),
        .cmd          (cmd),
        .status       (status),
        .mirror_valid (mirror_valid),
        .mirror       (mirror)
    );

endmodule

>>> hdl/hml_ctrl.sv
module hml_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  logic                mirror_stall,
    input  hml_pkg::hml_status_t status,
    output hml_pkg::hml_cmd_t   cmd
);

    hml_pkg::hml_state_t state_reg;
    hml_pkg::hml_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hml_pkg::HML_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pixel_stall = 1'b1;
        cmd         = '0;
        // move a fetched word into the output register when it is free or leaving
        cmd.load    = status.rd_valid && (!status.out_valid || !mirror_stall);
        cmd.take    = status.out_valid && !mirror_stall;
        unique case (state_reg)
            hml_pkg::HML_FILL:
            begin
                pixel_stall = 1'b0;
                cmd.write   = pixel_valid;
                cmd.start   = pixel_valid && status.row_end;
                if (pixel_valid && status.row_end)
                begin
                    state_next = hml_pkg::HML_DRAIN;
                end
            end
            hml_pkg::HML_DRAIN:
            begin
                cmd.issue = status.reads_left && (!status.rd_valid || cmd.load);
                if (!status.reads_left && !status.rd_valid)
                begin
                    state_next = hml_pkg::HML_FILL;
                end
            end
            default:
            begin
                state_next = hml_pkg::HML_FILL;
            end
        endcase
    end

endmodule

>>> hdl/hml_datapath.sv
module hml_datapath #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [hml_pkg::ROW_WIDTH_W-1:0]      cfg_data,
    input  hml_pkg::pixel_t                      pixel,
    input  hml_pkg::hml_cmd_t                    cmd,
    output hml_pkg::hml_status_t                 status,
    output logic                                 mirror_valid,
    output hml_pkg::mirror_t                     mirror
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int NW = $clog2(MAX_WIDTH + 1);
    localparam int RW = hml_pkg::ROW_WIDTH_W;
    localparam logic [RW-1:0] MAX_W = RW'(MAX_WIDTH);

    hml_pkg::pixel_t  mem [MAX_WIDTH];

    logic [RW-1:0]    width_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [AW-1:0]    rd_addr_reg;
    logic [NW-1:0]    left_reg;
    hml_pkg::pixel_t  rd_data_reg;
    logic             rd_last_reg;
    logic             rd_valid_reg;
    logic             out_valid_reg;
    hml_pkg::mirror_t out_reg;

    logic [RW-1:0]    eff_width;
    logic [RW-1:0]    col_plus;
    logic             row_end;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = RW'(1);
        end
        else if (width_reg > MAX_W)
        begin
            eff_width = MAX_W;
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    assign col_plus = RW'(col_reg) + RW'(1);
    assign row_end  = col_plus >= eff_width;
    assign col_next = row_end ? '0 : col_plus[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= hml_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            width_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[col_reg] <= pixel;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_addr_reg];
            rd_last_reg <= (left_reg == NW'(1));
        end
        if (cmd.load)
        begin
            out_reg.out_red   <= rd_data_reg.in_red;
            out_reg.out_green <= rd_data_reg.in_green;
            out_reg.out_blue  <= rd_data_reg.in_blue;
            out_reg.row_done  <= rd_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            rd_addr_reg   <= '0;
            left_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                col_reg <= col_next;
            end
            // read out from the last column down to column zero
            if (cmd.start)
            begin
                rd_addr_reg <= AW'(eff_width - RW'(1));
                left_reg    <= NW'(eff_width);
            end
            else if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_reg - AW'(1);
                left_reg    <= left_reg - NW'(1);
            end
            if (cmd.issue)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (cmd.load)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.row_end    = row_end;
    assign status.reads_left = (left_reg != '0);
    assign status.rd_valid   = rd_valid_reg;
    assign status.out_valid  = out_valid_reg;

    assign mirror_valid = out_valid_reg;
    assign mirror       = out_reg;

endmodule

>>> dv/tb_horizontal_mirror_line_top.sv
module tb_horizontal_mirror_line_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = 64;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD_CYCLES = 160;
    localparam int RANDOM_PIXELS = 220;

    typedef enum logic {
        ROW_PIXEL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [23:0]      value;
        logic             typed;
        hml_pkg::mirror_t word;
    } plan_row_t;

    // Typed words only where the row is a single pixel wide.
    localparam plan_row_t PLAN [18] = '{
        '{ROW_PIXEL, 24'h102030, 1'b0, '0},
        '{ROW_PIXEL, 24'h405060, 1'b0, '0},
        '{ROW_PIXEL, 24'h708090, 1'b0, '0},
        '{ROW_CFG,   24'd2,      1'b0, '0},
        '{ROW_PIXEL, 24'hA0B0C0, 1'b0, '0},
        '{ROW_CFG,   24'd1,      1'b0, '0},
        '{ROW_PIXEL, 24'h000000, 1'b1, {24'h000000, 1'b1}},
        '{ROW_PIXEL, 24'hFFFFFF, 1'b1, {24'hFFFFFF, 1'b1}},
        '{ROW_CFG,   24'd0,      1'b0, '0},
        '{ROW_PIXEL, 24'hA55AC3, 1'b1, {24'hA55AC3, 1'b1}},
        '{ROW_CFG,   24'd4,      1'b0, '0},
        '{ROW_PIXEL, 24'h010203, 1'b0, '0},
        '{ROW_PIXEL, 24'h040506, 1'b0, '0},
        '{ROW_CFG,   24'd6,      1'b0, '0},
        '{ROW_PIXEL, 24'h070809, 1'b0, '0},
        '{ROW_PIXEL, 24'h0A0B0C, 1'b0, '0},
        '{ROW_PIXEL, 24'h0D0E0F, 1'b0, '0},
        '{ROW_PIXEL, 24'h101112, 1'b0, '0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            pixel_valid;
    logic                            pixel_stall;
    hml_pkg::pixel_t                 pixel;
    logic                            mirror_valid;
    logic                            mirror_stall;
    hml_pkg::mirror_t                mirror;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [hml_pkg::ROW_WIDTH_W-1:0] cfg_data;

    // Mirror state of the block
    hml_pkg::pixel_t                 line_buf [MAX_W];
    logic [5:0]                      fill_col;
    logic [hml_pkg::ROW_WIDTH_W-1:0] row_width;

    hml_pkg::mirror_t                pending_words [$];
    int                              errors = 0;
    bit                              calm = 1'b0;
    bit                              long_hold = 1'b0;

    always #6 clk = ~clk;

    horizontal_mirror_line_top #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .mirror_valid(mirror_valid),
        .mirror_stall(mirror_stall),
        .mirror      (mirror),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    function automatic int eff_width(logic [hml_pkg::ROW_WIDTH_W-1:0] w);
        if (w == 0)
        begin
            return 1;
        end
        if (w > MAX_W)
        begin
            return MAX_W;
        end
        return int'(w);
    endfunction

    // Store one pixel; return the mirrored row if this pixel completes it.
    task automatic mirror_pixel(input hml_pkg::pixel_t px, output hml_pkg::mirror_t words [$]);
        int w;
        int c;
        int k;
        w = eff_width(row_width);
        c = int'(fill_col);
        words = {};
        line_buf[c] = px;
        if (c + 1 < w)
        begin
            fill_col = 6'(c + 1);
        end
        else
        begin
            for (k = w - 1; k >= 0; k--)
            begin
                words.push_back({line_buf[k], (k == 0) ? 1'b1 : 1'b0});
            end
            fill_col = '0;
        end
    endtask

    task automatic send_pixel(input hml_pkg::pixel_t px, input logic typed,
                              input hml_pkg::mirror_t typed_word);
        int gap;
        hml_pkg::mirror_t words [$];
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= px;
        do @(posedge clk); while (pixel_stall);
        mirror_pixel(px, words);
        if (typed)
        begin
            pending_words.push_back(typed_word);
        end
        else
        begin
            foreach (words[i])
            begin
                pending_words.push_back(words[i]);
            end
        end
    endtask

    // Hold off new pixels until every expected word is out and the buffer write settles.
    task automatic drain();
        pixel_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [hml_pkg::ROW_WIDTH_W-1:0] w);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        row_width = w;
    endtask

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %h, got %h", name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        hml_pkg::mirror_t want;
        if (rst_n && mirror_valid && !mirror_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected mirror word %h", mirror);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("out_red", want.out_red, mirror.out_red);
                check_field("out_green", want.out_green, mirror.out_green);
                check_field("out_blue", want.out_blue, mirror.out_blue);
                check_field("row_done", 8'(want.row_done), 8'(mirror.row_done));
            end
        end
    end

    // Output back-pressure: random stall before each word, one long hold on request.
    initial
    begin
        int hold;
        mirror_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                hold = LONG_HOLD_CYCLES;
                long_hold = 1'b0;
            end
            else
            begin
                hold = calm ? 0 : $urandom_range(0, 7);
            end
            if (hold > 0)
            begin
                mirror_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            mirror_stall <= 1'b0;
            do @(posedge clk); while (!mirror_valid);
        end
    end

    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int phase;
        int sent;
        int eff;
        int count;
        logic [hml_pkg::ROW_WIDTH_W-1:0] wv;
        rst_n <= 1'b0;
        pixel_valid <= 1'b0;
        pixel <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        fill_col = '0;
        row_width = hml_pkg::ROW_WIDTH_RESET;
        foreach (line_buf[i])
        begin
            line_buf[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                set_width(PLAN[i].value[hml_pkg::ROW_WIDTH_W-1:0]);
            end
            else
            begin
                send_pixel(PLAN[i].value, PLAN[i].typed, PLAN[i].word);
            end
        end

        phase = 0;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            case (phase)
                0: wv = 7'd127;
                1: wv = 7'd64;
                2: wv = 7'd0;
                3: wv = 7'd5;
                4: wv = 7'd1;
                default: wv = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                           : 7'($urandom_range(1, 12));
            endcase
            set_width(wv);
            calm = (phase % 5 == 2);
            eff = eff_width(wv);
            if (phase == 0)
            begin
                count = eff;
            end
            else if (phase == 3)
            begin
                // Keep pixels coming while the output holds off, so the input backs up.
                count = 60;
                long_hold = 1'b1;
            end
            else if (eff >= 32)
            begin
                count = $urandom_range(1, eff);
            end
            else
            begin
                count = $urandom_range(1, 4) * eff;
                if ($urandom_range(0, 1) == 1)
                begin
                    count += $urandom_range(0, eff - 1);
                end
            end
            if (count > RANDOM_PIXELS - sent)
            begin
                count = RANDOM_PIXELS - sent;
            end
            repeat (count)
            begin
                send_pixel(24'($urandom()), 1'b0, '0);
            end
            sent += count;
            phase++;
        end

        calm = 1'b0;
        drain();
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
